// ===== rtl/gcpf_pkg.sv =====
// Shared types and constants for the gear-hash cut point finder.
// Used by gear_cut_point_finder_top and its port checker; no dependencies.
package gcpf_pkg;

	localparam int unsigned TABLE_DEPTH  = 256;
	localparam int unsigned LENGTH_LIMIT = 131072;

	localparam int unsigned LEN_W   = 18;
	localparam int unsigned MASK_W  = 32;
	localparam int unsigned HASH_W  = MASK_W;
	localparam int unsigned IDX_W   = $clog2(TABLE_DEPTH);
	localparam int unsigned VALUE_W = 64;
	localparam int unsigned CFG_W   = 32;
	localparam int unsigned S_DATA_W = 80;
	localparam int unsigned M_DATA_W = 24;
	localparam int unsigned FIFO_DEPTH = 4;

	localparam logic [LEN_W-1:0] LEN_LIMIT_V = LEN_W'(LENGTH_LIMIT);

	typedef enum logic [2:0] {
		CFG_MIN_SIZE   = 3'd0,
		CFG_AVG_SIZE   = 3'd1,
		CFG_MAX_SIZE   = 3'd2,
		CFG_SMALL_MASK = 3'd3,
		CFG_LARGE_MASK = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CAUSE_MATCH = 2'd0,
		CAUSE_MAX   = 2'd1,
		CAUSE_END   = 2'd2
	} cause_t;

	typedef enum logic {
		OP_DATA  = 1'b0,
		OP_TABLE = 1'b1
	} op_t;

	typedef struct packed {
		logic [LEN_W-1:0] len;
		cause_t           cause;
		logic             fin;
	} result_t;

endpackage

// ===== rtl/gear_cut_point_finder_top.sv =====
// A byte word is registered with its table entry, then its chunk results are queued.
// Throughput: one input word per cycle unless stalled; a word that closes two chunks
// yields two results for the four-entry result queue; input stalls while it holds 3+.
// Reset (arst_n low): registers to their default sizes and masks, hash and position
// cleared, queue emptied; gear table contents undefined until written.
// Depends on gcpf_pkg.
module gear_cut_point_finder_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [2:0]                     cfg_index,
	input  logic [gcpf_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// data_byte[7:0], table_index[15:8], table_value[79:16]
	input  logic [gcpf_pkg::S_DATA_W-1:0]  s_tdata,
	// op
	input  logic                           s_tuser,
	input  logic                           s_tlast,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// chunk_length[17:0], zero pad[23:18]
	output logic [gcpf_pkg::M_DATA_W-1:0]  m_tdata,
	// end_cause[1:0]
	output logic [1:0]                     m_tuser,
	output logic                           m_tlast
);
	import gcpf_pkg::*;

	localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

	logic [LEN_W-1:0]  min_size_q, avg_size_q, max_size_q;
	logic [MASK_W-1:0] small_mask_q, large_mask_q;

	logic [HASH_W-1:0] gear_mem [TABLE_DEPTH];

	logic              vld_s1, op_s1, last_s1;
	logic [HASH_W-1:0] tbl_s1;

	logic [HASH_W-1:0] hash_q;
	logic [LEN_W-1:0]  pos_q;

	result_t           fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	logic              s_acc, adv, pop;
	logic              work;
	logic [LEN_W-1:0]  eff_min, eff_max, pos_b, pos_inc;
	logic [HASH_W-1:0] hash_n, mask;
	logic              hashing, match, close;
	result_t           res0, res1;
	logic [1:0]        n_res;
	logic [HASH_W-1:0] hash_d;
	logic [LEN_W-1:0]  pos_d;

	assign adv      = vld_s1 && (count_q <= CNT_W'(FIFO_DEPTH - 2));
	assign s_tready = !vld_s1 || adv;
	assign s_acc    = s_tvalid && s_tready;
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_size_q   <= LEN_W'(2048);
			avg_size_q   <= LEN_W'(8192);
			max_size_q   <= LEN_W'(65536);
			small_mask_q <= MASK_W'(32767);
			large_mask_q <= MASK_W'(2047);
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_MIN_SIZE:   min_size_q   <= cfg_data[LEN_W-1:0];
				CFG_AVG_SIZE:   avg_size_q   <= cfg_data[LEN_W-1:0];
				CFG_MAX_SIZE:   max_size_q   <= cfg_data[LEN_W-1:0];
				CFG_SMALL_MASK: small_mask_q <= cfg_data[MASK_W-1:0];
				CFG_LARGE_MASK: large_mask_q <= cfg_data[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			if (op_t'(s_tuser) == OP_TABLE) begin
				gear_mem[s_tdata[15:8]] <= s_tdata[16 +: HASH_W];
			end
			tbl_s1 <= gear_mem[s_tdata[7:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_s1   <= s_tuser;
			last_s1 <= s_tlast;
		end
	end

	always_comb begin
		work    = adv && (op_t'(op_s1) == OP_DATA);
		eff_min = (min_size_q == '0) ? LEN_W'(1) : min_size_q;
		if (max_size_q == '0) begin
			eff_max = LEN_W'(1);
		end else if (max_size_q > LEN_LIMIT_V) begin
			eff_max = LEN_LIMIT_V;
		end else begin
			eff_max = max_size_q;
		end
		hash_n  = {hash_q[HASH_W-2:0], 1'b0} + tbl_s1;
		mask    = (pos_q < avg_size_q) ? small_mask_q : large_mask_q;
		hashing = pos_q >= eff_min;
		match   = hashing && ((hash_n & mask) == '0);
		pos_b   = match ? '0 : pos_q;
		pos_inc = pos_b + LEN_W'(1);
		close   = last_s1 || (pos_inc >= eff_max);

		res0 = '{len: pos_q, cause: CAUSE_MATCH, fin: !close};
		res1 = '{len: pos_inc, cause: last_s1 ? CAUSE_END : CAUSE_MAX, fin: 1'b1};
		if (!match) begin
			res0 = res1;
		end
		n_res = work ? (2'(match) + 2'(close)) : 2'd0;

		if (close) begin
			hash_d = '0;
			pos_d  = '0;
		end else begin
			hash_d = match ? '0 : (hashing ? hash_n : hash_q);
			pos_d  = pos_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= '0;
			pos_q  <= '0;
		end else if (work) begin
			hash_q <= hash_d;
			pos_q  <= pos_d;
		end
	end

	always_ff @(posedge clk) begin
		if (n_res != 2'd0) begin
			fifo_q[wr_ptr_q] <= res0;
		end
		if (n_res == 2'd2) begin
			fifo_q[wr_ptr_q + PTR_W'(1)] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_res);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			count_q  <= count_q + CNT_W'(n_res) - CNT_W'(pop);
		end
	end

	assign m_tvalid = count_q != '0;
	assign m_tdata  = M_DATA_W'(fifo_q[rd_ptr_q].len);
	assign m_tuser  = fifo_q[rd_ptr_q].cause;
	assign m_tlast  = fifo_q[rd_ptr_q].fin;

endmodule

// ===== rtl/gcpf_checker.sv =====
// Port-level checks on the cut point finder's result stream, and their bind.
// Depends on gcpf_pkg and gear_cut_point_finder_top.
module gcpf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [gcpf_pkg::M_DATA_W-1:0] m_tdata,
	input logic [1:0]                    m_tuser,
	input logic                          m_tlast
);
	import gcpf_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[LEN_W-1:0] != '0)
		else $error("empty chunk reported");

	a_forced_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == CAUSE_MAX || m_tuser == CAUSE_END) |-> m_tlast)
		else $error("size or buffer end not final");

	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser != CAUSE_MATCH)
		else $error("second result of a pair missing");

endmodule

bind gear_cut_point_finder_top gcpf_checker u_gcpf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

// ===== verif/testbench.sv =====
// Self-checking bench for gear_cut_point_finder_top: table load, directed cut cases,
// a long maximum-size chunk, output back-pressure and randomised buffers against a predictor.
// Depends on gcpf_pkg and the RTL of the cut point finder.
module testbench;
	import gcpf_pkg::*;

	localparam int unsigned IDLE_MAX     = 6;
	localparam int unsigned FLUSH_CYCLES = 6;
	localparam int unsigned HOLD_CYCLES  = 300;
	localparam int unsigned LONG_CHUNK   = 600;
	localparam int unsigned RANDOM_WORDS = 900;
	localparam int unsigned DRAIN_LIMIT  = 5000;
	localparam int unsigned REPORT_MAX   = 10;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [2:0]            cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_DATA_W-1:0]   s_tdata   = '0;
	logic                  s_tuser   = 1'b0;
	logic                  s_tlast   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_DATA_W-1:0]   m_tdata;
	logic [1:0]            m_tuser;
	logic                  m_tlast;

	// predictor state and register mirror
	logic [VALUE_W-1:0] gear_tab [TABLE_DEPTH];
	logic [63:0]        cut_hash  = '0;
	int unsigned        chunk_pos = 0;
	int unsigned        min_len   = 2048;
	int unsigned        avg_len   = 8192;
	int unsigned        max_len   = 65536;
	logic [MASK_W-1:0]  small_m   = 32'd32767;
	logic [MASK_W-1:0]  large_m   = 32'd2047;

	result_t     chunks_due [$];
	int unsigned mismatches    = 0;
	int unsigned words_in      = 0;
	int unsigned chunks_seen   = 0;
	int unsigned reg_writes    = 0;
	int unsigned send_gap_max  = IDLE_MAX;
	int unsigned sink_gap_max  = IDLE_MAX;
	int unsigned sink_wait     = 0;
	int unsigned sink_draw;
	logic        sink_hold     = 1'b0;

	gear_cut_point_finder_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always #4 clk = ~clk;

	function automatic void predict_cuts(op_t op, logic [7:0] b, logic last,
			logic [7:0] idx, logic [VALUE_W-1:0] val);
		result_t           cut [2];
		int unsigned       n_cut;
		int unsigned       at;
		int unsigned       lo;
		int unsigned       hi;
		logic [MASK_W-1:0] mask;
		if (op == OP_TABLE) begin
			gear_tab[idx] = val;
			return;
		end
		n_cut = 0;
		lo = (min_len == 0) ? 1 : min_len;
		hi = (max_len == 0) ? 1 : max_len;
		if (hi > LENGTH_LIMIT)
			hi = LENGTH_LIMIT;
		at = chunk_pos;
		if (at >= lo) begin
			cut_hash = (cut_hash << 1) + gear_tab[b];
			mask = (at < avg_len) ? small_m : large_m;
			if ((cut_hash[MASK_W-1:0] & mask) == '0) begin
				cut[n_cut] = '{len: LEN_W'(at), cause: CAUSE_MATCH, fin: 1'b0};
				n_cut++;
				cut_hash = '0;
				at = 0;
			end
		end
		if (last) begin
			cut[n_cut] = '{len: LEN_W'(at + 1), cause: CAUSE_END, fin: 1'b0};
			n_cut++;
			cut_hash = '0;
			chunk_pos = 0;
		end else if (at + 1 >= hi) begin
			cut[n_cut] = '{len: LEN_W'(at + 1), cause: CAUSE_MAX, fin: 1'b0};
			n_cut++;
			cut_hash = '0;
			chunk_pos = 0;
		end else begin
			chunk_pos = at + 1;
		end
		if (n_cut != 0)
			cut[n_cut - 1].fin = 1'b1;
		for (int k = 0; k < n_cut; k++)
			chunks_due.push_back(cut[k]);
	endfunction

	function automatic void flag_mismatch(string field, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("mismatch on %s: expected %0d, got %0d", field, want, got);
	endfunction

	function automatic logic [31:0] rand_size(int unsigned hi);
		logic [31:0] noise;
		noise = $urandom;
		case ($urandom_range(0, 4))
			0: return '0;
			1: return 32'd1;
			2: return '1;
			3: return {noise[31:LEN_W], LEN_W'($urandom_range(2, hi))};
			default: return $urandom_range(2, hi);
		endcase
	endfunction

	function automatic logic [31:0] rand_mask();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			2: return (32'd1 << $urandom_range(0, 6)) - 32'd1;
			default: return $urandom;
		endcase
	endfunction

	// output side: random stalls after each word, long hold on request
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (sink_hold) begin
			m_tready <= 1'b0;
		end else if (sink_wait != 0) begin
			sink_wait <= sink_wait - 1;
			m_tready <= (sink_wait == 1);
		end else if (m_tvalid && m_tready) begin
			sink_draw = $urandom_range(0, sink_gap_max);
			sink_wait <= sink_draw;
			m_tready <= (sink_draw == 0);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			chunks_seen++;
			if (chunks_due.size() == 0) begin
				flag_mismatch("unexpected chunk length", '0, 32'(m_tdata));
			end else begin
				want = chunks_due.pop_front();
				if (m_tdata !== M_DATA_W'(want.len))
					flag_mismatch("chunk_length", 32'(want.len), 32'(m_tdata));
				if (m_tuser !== want.cause)
					flag_mismatch("end_cause", 32'(want.cause), 32'(m_tuser));
				if (m_tlast !== want.fin)
					flag_mismatch("final_result", 32'(want.fin), 32'(m_tlast));
			end
		end
	end

	task automatic push_word(op_t op, logic [7:0] b, logic last, logic [7:0] idx,
			logic [VALUE_W-1:0] val);
		int unsigned gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tlast  <= last;
		s_tdata  <= {val, idx, b};
		do @(posedge clk); while (!s_tready);
		predict_cuts(op, b, last, idx, val);
		words_in++;
	endtask

	task automatic send_byte(logic [7:0] b, logic last);
		push_word(OP_DATA, b, last, 8'($urandom), {$urandom, $urandom});
	endtask

	task automatic send_table(logic [7:0] idx, logic [VALUE_W-1:0] val);
		push_word(OP_TABLE, 8'($urandom), 1'($urandom), idx, val);
	endtask

	task automatic reg_write(logic [2:0] index, logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (index)
			CFG_MIN_SIZE:   min_len = value[LEN_W-1:0];
			CFG_AVG_SIZE:   avg_len = value[LEN_W-1:0];
			CFG_MAX_SIZE:   max_len = value[LEN_W-1:0];
			CFG_SMALL_MASK: small_m = value[MASK_W-1:0];
			CFG_LARGE_MASK: large_m = value[MASK_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	// hold input low until every expected chunk is out and the pipe is empty
	task automatic settle();
		s_tvalid <= 1'b0;
		while (chunks_due.size() != 0) @(posedge clk);
		repeat (FLUSH_CYCLES) @(posedge clk);
	endtask

	task automatic set_sizes(logic [31:0] mn, logic [31:0] av, logic [31:0] mx,
			logic [31:0] sm, logic [31:0] lg);
		settle();
		reg_write(CFG_MIN_SIZE, mn);
		reg_write(CFG_AVG_SIZE, av);
		reg_write(CFG_MAX_SIZE, mx);
		reg_write(CFG_SMALL_MASK, sm);
		reg_write(CFG_LARGE_MASK, lg);
	endtask

	task automatic test_table_load();
		for (int i = 0; i < TABLE_DEPTH; i++)
			send_table(8'(i), {$urandom, $urandom});
	endtask

	task automatic test_directed_cases();
		// min and average of zero: every hashed word matches
		set_sizes('0, '0, 32'd3, '1, '0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h5A, 1'b0);
		send_byte(8'hA5, 1'b1);
		// table extremes written mid-chunk
		set_sizes(32'd1, 32'd4, 32'd20, '1, 32'd1);
		send_byte(8'h11, 1'b0);
		send_table(8'h00, '0);
		send_table(8'hFF, '1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		// max of zero acts as one
		set_sizes(32'd4, 32'd8, '0, '1, '1);
		send_byte(8'h3C, 1'b0);
		send_byte(8'hC3, 1'b0);
		send_byte(8'h81, 1'b1);
		// no hashing: last word on the maximum, then a plain maximum cut
		set_sizes('1, 32'd8, 32'd3, '0, '0);
		repeat (2) send_byte(8'($urandom), 1'b0);
		send_byte(8'($urandom), 1'b1);
		repeat (3) send_byte(8'($urandom), 1'b0);
		// writes beyond the register list change nothing
		settle();
		for (int i = int'(CFG_LARGE_MASK) + 1; i < 8; i++)
			reg_write(3'(i), $urandom);
		repeat (3) send_byte(8'($urandom), 1'b0);
	endtask

	task automatic test_length_limit();
		set_sizes('1, '1, 32'(LONG_CHUNK), '1, '1);
		send_gap_max = 0;
		repeat (LONG_CHUNK) send_byte(8'($urandom), 1'b0);
		send_gap_max = IDLE_MAX;
	endtask

	task automatic test_backpressure();
		set_sizes('0, '0, 32'd50, '0, '0);
		send_gap_max = 0;
		fork
			begin
				@(posedge clk);
				sink_hold <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				sink_hold <= 1'b0;
			end
			begin
				for (int i = 0; i < 80; i++)
					send_byte(8'($urandom), $urandom_range(0, 5) == 0);
			end
		join
		send_gap_max = IDLE_MAX;
	endtask

	task automatic test_random_buffers();
		int unsigned stop_at;
		int unsigned phase_end;
		int unsigned run;
		int unsigned kind;
		stop_at = words_in + RANDOM_WORDS;
		while (words_in < stop_at) begin
			set_sizes(rand_size(24), rand_size(48), rand_size(96), rand_mask(), rand_mask());
			phase_end = words_in + $urandom_range(150, 300);
			while (words_in < phase_end && words_in < stop_at) begin
				send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
				sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
				kind = $urandom_range(0, 15);
				if (kind == 0) begin
					settle();
				end else if (kind == 1) begin
					repeat ($urandom_range(1, 4)) send_table(8'($urandom), {$urandom, $urandom});
				end else if (kind < 4) begin
					repeat ($urandom_range(1, 30))
						send_byte(8'($urandom), $urandom_range(0, 7) == 0);
				end else begin
					run = $urandom_range(1, 120);
					for (int k = 1; k <= run; k++) begin
						if ($urandom_range(0, 40) == 0)
							send_table(8'($urandom), {$urandom, $urandom});
						send_byte(8'($urandom), k == run);
					end
				end
			end
		end
		send_gap_max = IDLE_MAX;
		sink_gap_max = IDLE_MAX;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_load();
		test_directed_cases();
		test_length_limit();
		test_backpressure();
		test_random_buffers();
		s_tvalid <= 1'b0;
		for (int i = 0; i < DRAIN_LIMIT && chunks_due.size() != 0; i++)
			@(posedge clk);
		repeat (FLUSH_CYCLES) @(posedge clk);
		if (chunks_due.size() != 0) begin
			mismatches += chunks_due.size();
			$display("%0d chunk results never arrived", chunks_due.size());
		end
		$display("%0d words driven, %0d register writes, %0d chunk results checked",
			words_in, reg_writes, chunks_seen);
		$display("covered table load, match/maximum/end cuts, a long maximum chunk, stalls");
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#8000000;
		$display("simulation failed");
		$finish;
	end

endmodule
